[rtl/core/pid_tilt_motor_controller_defines.svh]
// Assertion helpers for the controller top level.
`ifndef PID_TILT_MOTOR_CONTROLLER_DEFINES_SVH
`define PID_TILT_MOTOR_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PIDT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PIDT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pidt_pkg.sv]
package pidt_pkg;

  typedef struct packed {
    logic signed [15:0] angle;
    logic [15:0]        sample_period;
  } in_t;

  typedef struct packed {
    logic signed [15:0] control_value;
    logic [1:0]         motor_command;
    logic [14:0]        duty_percent;
    logic               tilt_fault;
  } out_t;

  // Register indexes on the config port
  localparam logic [2:0] REG_TARGET  = 3'd0;
  localparam logic [2:0] REG_GAIN_P  = 3'd1;
  localparam logic [2:0] REG_GAIN_I  = 3'd2;
  localparam logic [2:0] REG_GAIN_D  = 3'd3;
  localparam logic [2:0] REG_TAU     = 3'd4;
  localparam logic [2:0] REG_OUT_MAX = 3'd5;
  localparam logic [2:0] REG_OUT_MIN = 3'd6;
  localparam logic [2:0] REG_TILT    = 3'd7;

  localparam logic [1:0] MOTOR_STOP = 2'd0;
  localparam logic [1:0] MOTOR_FWD  = 2'd1;
  localparam logic [1:0] MOTOR_BWD  = 2'd2;

  localparam logic [14:0] DUTY_BASE = 15'd6400;
  localparam logic [14:0] DUTY_MAX  = 15'd25600;

  typedef enum logic [3:0] {
    CMD_IDLE, CMD_LOAD, CMD_MUL, CMD_INC, CMD_INT, CMD_DIV1, CMD_REST,
    CMD_DIV2, CMD_DUPD, CMD_DMUL, CMD_SUM, CMD_OUT
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_INC, ST_INT, ST_DIV1, ST_WAIT1, ST_REST,
    ST_DIV2, ST_WAIT2, ST_DUPD, ST_DMUL, ST_SUM, ST_OUT
  } st_t;

  typedef struct packed {
    logic den_zero;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

[rtl/core/pidt_div.sv]
// Floor division of a signed value by an unsigned divisor, one bit a cycle.
module pidt_div import pidt_pkg::*; #(
  parameter int NW  = 36,
  parameter int DNW = 18
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DNW-1:0]       den,
  output logic                 done,
  output logic signed [NW-1:0] quo,
  output logic [DNW-1:0]       rem
);

  localparam int CNTW = $clog2(NW + 1);

  logic              busy_r, fix_r, done_r, neg_r;
  logic [CNTW-1:0]   cnt_r;
  logic [NW-1:0]     acc_r;
  logic [DNW-1:0]    rem_r, den_r, remo_r;
  logic signed [NW-1:0] quo_r;
  logic [DNW:0]      trial;
  logic              fit;
  logic              r_nz;

  assign trial = {rem_r, acc_r[NW-1]};
  assign fit   = trial >= {1'b0, den_r};
  assign r_nz  = rem_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
        neg_r  <= num[NW-1];
        acc_r  <= num[NW-1] ? NW'(-num) : NW'(num);
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= fit ? DNW'(trial - {1'b0, den_r}) : trial[DNW-1:0];
        acc_r <= {acc_r[NW-2:0], fit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end else if (fix_r) begin
        // round toward minus infinity for negative dividends
        fix_r  <= 1'b0;
        done_r <= 1'b1;
        if (neg_r) begin
          quo_r  <= $signed(-acc_r) - $signed(NW'(r_nz));
          remo_r <= r_nz ? DNW'(den_r - rem_r) : '0;
        end else begin
          quo_r  <= $signed(acc_r);
          remo_r <= rem_r;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = remo_r;

endmodule

[rtl/core/pidt_dp.sv]
// PID datapath: config registers, loop state, arithmetic steps, result register.
module pidt_dp import pidt_pkg::*; #(
  parameter int STATE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  in_t         in_data,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        out_stall,
  output logic        out_valid,
  output out_t        out_data,
  output stat_t       status
);

  localparam int W   = STATE_WIDTH;
  localparam int CW  = ((W > 37) ? W : 37) + 2;
  localparam int XW  = W + 2;
  localparam int DVW = (XW > 36) ? XW : 36;
  localparam int DNW = W + 19;
  localparam int GW  = W + 18;
  localparam int SW  = W + 8;
  localparam int TW  = W + 6;
  localparam int KW  = W + 5;

  // configuration
  logic signed [15:0] tgt_r, omax_r, omin_r;
  logic [15:0]        gp_r, gi_r, gd_r, tau_r;
  logic [14:0]        tilt_r;

  // loop state
  logic signed [W-1:0] integ_r, deriv_r;
  logic signed [16:0]  last_err_r;
  logic signed [15:0]  last_ang_r;

  // per-sample working registers
  logic signed [15:0]  angle_r;
  logic [15:0]         t_r;
  logic signed [16:0]  err_r;
  logic signed [28:0]  p_r;
  logic [31:0]         gt_r;
  logic signed [17:0]  esum_r, a_r, ddiff_r;
  logic [17:0]         den_r;
  logic signed [37:0]  inc_r;
  logic signed [XW-1:0] x_r, q1_r;
  logic signed [35:0]  rest_r;
  logic signed [W:0]   pdh_r;
  logic [31:0]         pdl_r;
  logic signed [15:0]  ctl_r;
  logic                out_valid_r;
  out_t                out_r;

  // divider
  logic                  div_start, div_done;
  logic signed [DVW-1:0] div_num, div_quo;
  logic [17:0]           div_rem;

  assign div_start = (cmd == CMD_DIV1) || (cmd == CMD_DIV2);
  assign div_num   = (cmd == CMD_DIV1) ? DVW'(x_r) : DVW'(rest_r);

  pidt_div #(.NW(DVW), .DNW(18)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // arithmetic
  logic signed [33:0]   prod_p;
  logic signed [50:0]   inc_prod;
  logic signed [XW-1:0] x_prod;
  logic signed [34:0]   adl;
  logic signed [18:0]   omax8, omin8;
  logic signed [29:0]   hi_d, lo_d, lim_hi, lim_lo;
  logic signed [CW-1:0] isum, iclamp;
  logic signed [W-1:0]  inew;
  logic signed [35:0]   rest_sum;
  logic signed [DNW-1:0] dsum;
  logic signed [W-1:0]  dnew;
  logic signed [GW-1:0] gdd;
  logic signed [TW-1:0] dterm;
  logic signed [SW-1:0] psum;
  logic signed [KW-1:0] ctl_full;
  logic signed [15:0]   ctl_c;
  logic signed [16:0]   ang_x, tilt_p, tilt_n;
  logic                 fault;
  logic [16:0]          mag;
  logic [19:0]          mag5;
  logic [15:0]          duty_raw;
  out_t                 res;

  always_comb begin
    prod_p   = $signed({1'b0, gp_r}) * err_r;
    inc_prod = $signed({1'b0, gt_r}) * esum_r;
    x_prod   = a_r * $signed(deriv_r[W-1:16]);
    adl      = a_r * $signed({1'b0, deriv_r[15:0]});

    // integrator with dynamic anti-windup bounds
    omax8  = {omax_r, 3'b000};
    omin8  = {omin_r, 3'b000};
    hi_d   = 30'(omax8) - 30'(p_r);
    lo_d   = 30'(omin8) - 30'(p_r);
    lim_hi = (hi_d > 30'sd0) ? hi_d : 30'sd0;
    lim_lo = (lo_d < 30'sd0) ? lo_d : 30'sd0;
    isum   = CW'(integ_r) + CW'(inc_r);
    if (isum > CW'(lim_hi)) iclamp = CW'(lim_hi);
    else if (isum < CW'(lim_lo)) iclamp = CW'(lim_lo);
    else iclamp = isum;
    if (iclamp[CW-1:W-1] == {(CW-W+1){iclamp[CW-1]}}) inew = iclamp[W-1:0];
    else inew = {iclamp[CW-1], {(W-1){~iclamp[CW-1]}}};

    // filtered derivative, second quotient numerator and recombination
    rest_sum = $signed({2'b00, div_rem, 16'h0000}) + 36'(adl)
             + 36'($signed({ddiff_r, 16'h0000}));
    dsum = (DNW'(q1_r) <<< 16) + DNW'(div_quo);
    if (dsum[DNW-1:W-1] == {(DNW-W+1){dsum[DNW-1]}}) dnew = dsum[W-1:0];
    else dnew = {dsum[DNW-1], {(W-1){~dsum[DNW-1]}}};

    // output sum and clamp
    gdd      = (GW'(pdh_r) <<< 16) + GW'($signed({1'b0, pdl_r}));
    dterm    = gdd[GW-1:12];
    psum     = SW'(p_r) + SW'(integ_r) - SW'(dterm);
    ctl_full = psum[SW-1:3];
    if (ctl_full > KW'(omax_r)) ctl_c = omax_r;
    else if (ctl_full < KW'(omin_r)) ctl_c = omin_r;
    else ctl_c = ctl_full[15:0];

    // motor command
    ang_x  = 17'(angle_r);
    tilt_p = $signed({2'b00, tilt_r});
    tilt_n = -tilt_p;
    fault  = (ang_x > tilt_p) || (ang_x < tilt_n);
    mag    = ctl_r[15] ? 17'(-17'(ctl_r)) : 17'(ctl_r);
    mag5   = ({3'b000, mag} << 2) + {3'b000, mag};
    duty_raw = 16'(DUTY_BASE) + 16'(mag5[19:3]);
    res.control_value = ctl_r;
    res.tilt_fault    = fault;
    if (fault || ctl_r == 16'sd0) begin
      res.motor_command = MOTOR_STOP;
      res.duty_percent  = '0;
    end else begin
      res.motor_command = ctl_r[15] ? MOTOR_BWD : MOTOR_FWD;
      res.duty_percent  = (duty_raw > 16'(DUTY_MAX)) ? DUTY_MAX : duty_raw[14:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r  <= '0;
      gp_r   <= '0;
      gi_r   <= '0;
      gd_r   <= '0;
      tau_r  <= '0;
      omax_r <= 16'sd8192;
      omin_r <= -16'sd8192;
      tilt_r <= 15'd7680;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET:  tgt_r  <= cfg_data;
        REG_GAIN_P:  gp_r   <= cfg_data;
        REG_GAIN_I:  gi_r   <= cfg_data;
        REG_GAIN_D:  gd_r   <= cfg_data;
        REG_TAU:     tau_r  <= cfg_data;
        REG_OUT_MAX: omax_r <= cfg_data;
        REG_OUT_MIN: omin_r <= cfg_data;
        REG_TILT:    tilt_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // loop state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      deriv_r     <= '0;
      last_err_r  <= '0;
      last_ang_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd == CMD_INT) integ_r <= inew;
      if (cmd == CMD_DUPD) deriv_r <= (den_r == '0) ? '0 : dnew;
      if (cmd == CMD_OUT) begin
        last_err_r  <= err_r;
        last_ang_r  <= angle_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        angle_r <= in_data.angle;
        t_r     <= in_data.sample_period;
        err_r   <= 17'(tgt_r) - 17'(in_data.angle);
      end
      CMD_MUL: begin
        p_r     <= prod_p[32:4];
        gt_r    <= gi_r * t_r;
        esum_r  <= 18'(err_r) + 18'(last_err_r);
        den_r   <= {1'b0, tau_r, 1'b0} + {2'b00, t_r};
        a_r     <= $signed({1'b0, tau_r, 1'b0}) - $signed({2'b00, t_r});
        ddiff_r <= $signed({17'(angle_r) - 17'(last_ang_r), 1'b0});
      end
      CMD_INC: begin
        inc_r <= inc_prod[50:13];
        x_r   <= x_prod;
      end
      CMD_REST: begin
        q1_r   <= div_quo[XW-1:0];
        rest_r <= rest_sum;
      end
      CMD_DMUL: begin
        pdh_r <= $signed({1'b0, gd_r}) * $signed(deriv_r[W-1:16]);
        pdl_r <= gd_r * deriv_r[15:0];
      end
      CMD_SUM: ctl_r <= ctl_c;
      CMD_OUT: out_r <= res;
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign status.den_zero = den_r == '0;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || !out_stall;

endmodule

[rtl/core/pidt_ctrl.sv]
// Sequencer for one PID update.
module pidt_ctrl import pidt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output cmd_t  cmd,
  input  stat_t status
);

  st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_INC;
      ST_INC:   state_nxt = ST_INT;
      ST_INT:   state_nxt = status.den_zero ? ST_DUPD : ST_DIV1;
      ST_DIV1:  state_nxt = ST_WAIT1;
      ST_WAIT1: if (status.div_done) state_nxt = ST_REST;
      ST_REST:  state_nxt = ST_DIV2;
      ST_DIV2:  state_nxt = ST_WAIT2;
      ST_WAIT2: if (status.div_done) state_nxt = ST_DUPD;
      ST_DUPD:  state_nxt = ST_DMUL;
      ST_DMUL:  state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_OUT;
      ST_OUT:   if (status.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = CMD_IDLE;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd = CMD_LOAD;
      end
      ST_MUL:  cmd = CMD_MUL;
      ST_INC:  cmd = CMD_INC;
      ST_INT:  cmd = CMD_INT;
      ST_DIV1: cmd = CMD_DIV1;
      ST_REST: cmd = CMD_REST;
      ST_DIV2: cmd = CMD_DIV2;
      ST_DUPD: cmd = CMD_DUPD;
      ST_DMUL: cmd = CMD_DMUL;
      ST_SUM:  cmd = CMD_SUM;
      ST_OUT:  if (status.out_free) cmd = CMD_OUT;
      default: cmd = CMD_IDLE;
    endcase
  end

endmodule

[rtl/core/pid_tilt_motor_controller.sv]
// Each request steps through the sequencer states from request to result; the bit-serial divider
//   runs twice, and both divides are skipped when 2*filter_tau + sample_period is zero.
// A new request is taken only once the current update has finished;
//   a result stalled at the output holds back only the next request's output step.
// Reset: rst_n synchronous, active low; clears integrator, derivative, last error and
//   last angle, loads register defaults, empties the output register.
`include "pid_tilt_motor_controller_defines.svh"

module pid_tilt_motor_controller import pidt_pkg::*; #(
  parameter int STATE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t  cmd;
  stat_t status;

  // Register writes are always taken; the user must issue them only while idle, as the block does not enforce it.
  assign cfg_ready = 1'b1;

  // Sequencer: steps the datapath through multiply, integrate, two divides (skipped
  // for a zero denominator), derivative gain and output mapping for each request.
  pidt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // Datapath: holds registers, loop state and the output register.
  pidt_dp #(.STATE_WIDTH(STATE_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

  // A taken request keeps the input stalled until its update finishes.
  `PIDT_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request not held off")
  // A stopped motor drives no duty.
  `PIDT_ASSERT_NOW(a_stop_no_duty, out_valid && out_data.motor_command == MOTOR_STOP, out_data.duty_percent == 15'd0, "duty while stopped")
  // A tilt fault always stops the motor.
  `PIDT_ASSERT_NOW(a_fault_stops, out_valid && out_data.tilt_fault, out_data.motor_command == MOTOR_STOP, "fault without stop")
  // A running motor stays within the duty band.
  `PIDT_ASSERT_NOW(a_duty_band, out_valid && out_data.motor_command != MOTOR_STOP, out_data.duty_percent >= DUTY_BASE && out_data.duty_percent <= DUTY_MAX, "duty out of band")

endmodule
